### sv/smsg_pkg.sv
// Package for the stable multikey sort grouper.
// Holds payload structs, size defaults and controller state codes; no dependencies.
package smsg_pkg;

    localparam int MaxRegionsDef = 64;
    localparam int MaxKeysDef    = 4;
    localparam int KeyWidthDef   = 32;
    localparam int KeyFields     = 4;
    localparam int CfgWidth      = 3;

    typedef struct packed {
        logic signed [31:0] region_number;
        logic signed [31:0] key_0;
        logic signed [31:0] key_1;
        logic signed [31:0] key_2;
        logic signed [31:0] key_3;
        logic [3:0]         element_type;
        logic               last_region;
    } item_t;

    typedef struct packed {
        logic signed [31:0] sorted_region;
        logic               group_start;
        logic [5:0]         group_index;
        logic               dropped;
        logic               last_out;
    } result_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic last_scan;
        logic out_free;
        logic last_emit;
    } status_t;

    typedef enum logic [1:0] {
        S_LOAD,
        S_SCAN,
        S_DRAIN,
        S_EMIT
    } state_t;

endpackage

### sv/smsg_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module smsg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### sv/smsg_ctrl.sv
// Controller state machine for the sort grouper: load, scan passes, emission.
// Depends on smsg_pkg.
module smsg_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  logic              item_last,
    output logic              item_stall,
    input  smsg_pkg::status_t status,
    output smsg_pkg::cmd_t    cmd
);

    smsg_pkg::state_t state_reg;
    smsg_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= smsg_pkg::S_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        item_stall = 1'b1;
        unique case (state_reg)
            smsg_pkg::S_LOAD:
            begin
                item_stall = 1'b0;
                if (item_valid)
                begin
                    cmd.load = 1'b1;
                    if (item_last)
                    begin
                        state_next = smsg_pkg::S_SCAN;
                    end
                end
            end
            smsg_pkg::S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (status.last_scan)
                begin
                    state_next = smsg_pkg::S_DRAIN;
                end
            end
            smsg_pkg::S_DRAIN:
            begin
                state_next = smsg_pkg::S_EMIT;
            end
            smsg_pkg::S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = status.last_emit ? smsg_pkg::S_LOAD : smsg_pkg::S_SCAN;
                end
            end
            default:
            begin
                state_next = smsg_pkg::S_LOAD;
            end
        endcase
    end

endmodule

### sv/smsg_dp.sv
// Datapath for the sort grouper: entry RAM, minimum search, group tracking, output register.
// Depends on smsg_pkg and smsg_ram.
module smsg_dp #(
    parameter int MAX_REGIONS = smsg_pkg::MaxRegionsDef,
    parameter int MAX_KEYS    = smsg_pkg::MaxKeysDef,
    parameter int KEY_WIDTH   = smsg_pkg::KeyWidthDef
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  smsg_pkg::item_t                 item,
    input  logic                            cfg_we,
    input  logic [smsg_pkg::CfgWidth-1:0]   cfg_data,
    input  smsg_pkg::cmd_t                  cmd,
    output smsg_pkg::status_t               status,
    output logic                            result_valid,
    input  logic                            result_stall,
    output smsg_pkg::result_t               result
);

    localparam int IW = $clog2(MAX_REGIONS);
    localparam int CW = $clog2(MAX_REGIONS + 1);
    localparam int KB = MAX_KEYS * KEY_WIDTH;
    localparam int WW = 32 + KB + 4;
    localparam int NK = (MAX_KEYS < smsg_pkg::KeyFields) ? MAX_KEYS : smsg_pkg::KeyFields;

    logic [CW-1:0]          count_reg;
    logic                   overflow_reg;
    logic [smsg_pkg::CfgWidth-1:0] kiu_reg;
    logic [IW-1:0]          scan_idx_reg;
    logic                   rd_valid_reg;
    logic [IW-1:0]          rd_idx_reg;
    logic                   best_valid_reg;
    logic [IW-1:0]          best_idx_reg;
    logic [WW-1:0]          best_reg;
    logic [WW-1:0]          prev_reg;
    logic [IW-1:0]          emit_cnt_reg;
    logic [MAX_REGIONS-1:0] done_reg;
    logic                   out_valid_reg;
    logic [5:0]             group_reg;
    smsg_pkg::result_t      out_reg;

    logic [WW-1:0]          wdata;
    logic [WW-1:0]          rdata;
    logic                   wen;
    logic [3:0]             nk;
    logic [IW-1:0]          last_idx;
    logic [1:0]             cmp_take;
    logic [1:0]             cmp_prev;
    logic                   take;
    logic                   same_prev;
    logic                   first_emit;
    logic                   finish;
    logic [5:0]             group_next;
    logic signed [63:0]     kext [smsg_pkg::KeyFields];

    function automatic logic [1:0] tuple_cmp(
        input logic [WW-1:0] a,
        input logic [WW-1:0] b,
        input logic [3:0]    n
    );
        logic lt;
        logic decided;
        logic signed [KEY_WIDTH-1:0] ka;
        logic signed [KEY_WIDTH-1:0] kb;
        lt      = 1'b0;
        decided = 1'b0;
        for (int k = 0; k < NK; k++)
        begin
            ka = a[4 + k * KEY_WIDTH +: KEY_WIDTH];
            kb = b[4 + k * KEY_WIDTH +: KEY_WIDTH];
            if (!decided && (4'(k) < n))
            begin
                if (ka < kb)
                begin
                    lt      = 1'b1;
                    decided = 1'b1;
                end
                else if (ka > kb)
                begin
                    decided = 1'b1;
                end
            end
        end
        if (!decided)
        begin
            lt = a[3:0] < b[3:0];
        end
        return {lt, !decided && (a[3:0] == b[3:0])};
    endfunction

    always_comb
    begin
        kext[0] = 64'(item.key_0);
        kext[1] = 64'(item.key_1);
        kext[2] = 64'(item.key_2);
        kext[3] = 64'(item.key_3);
        wdata   = '0;
        wdata[WW-1 -: 32] = item.region_number;
        wdata[3:0]        = item.element_type;
        for (int k = 0; k < NK; k++)
        begin
            wdata[4 + k * KEY_WIDTH +: KEY_WIDTH] = kext[k][KEY_WIDTH-1:0];
        end
    end

    always_comb
    begin
        nk = {1'b0, kiu_reg};
        if (nk > 4'(NK))
        begin
            nk = 4'(NK);
        end
    end

    assign wen        = cmd.load && (count_reg < CW'(MAX_REGIONS));
    assign last_idx   = IW'(count_reg - CW'(1));
    assign cmp_take   = tuple_cmp(rdata, best_reg, nk);
    assign cmp_prev   = tuple_cmp(best_reg, prev_reg, nk);
    assign take       = rd_valid_reg && !done_reg[rd_idx_reg]
                        && (!best_valid_reg || cmp_take[1]);
    assign same_prev  = cmp_prev[0];
    assign first_emit = (emit_cnt_reg == '0);
    assign finish     = emit_cnt_reg == last_idx;
    assign group_next = first_emit ? 6'd0 : (group_reg + 6'(!same_prev));

    assign status.last_scan = scan_idx_reg == last_idx;
    assign status.out_free  = !out_valid_reg || !result_stall;
    assign status.last_emit = finish;

    smsg_ram #(
        .WIDTH(WW),
        .DEPTH(MAX_REGIONS)
    ) u_ram (
        .clk  (clk),
        .we   (wen),
        .waddr(count_reg[IW-1:0]),
        .wdata(wdata),
        .raddr(scan_idx_reg),
        .rdata(rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            overflow_reg   <= 1'b0;
            kiu_reg        <= '0;
            scan_idx_reg   <= '0;
            rd_valid_reg   <= 1'b0;
            best_valid_reg <= 1'b0;
            emit_cnt_reg   <= '0;
            done_reg       <= '0;
            out_valid_reg  <= 1'b0;
            group_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                kiu_reg <= cfg_data;
            end
            if (cmd.load)
            begin
                if (wen)
                begin
                    count_reg <= count_reg + CW'(1);
                end
                else
                begin
                    overflow_reg <= 1'b1;
                end
            end
            rd_valid_reg <= cmd.scan;
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.emit)
            begin
                best_valid_reg <= 1'b0;
                scan_idx_reg   <= '0;
                group_reg      <= group_next;
                if (finish)
                begin
                    count_reg    <= '0;
                    overflow_reg <= 1'b0;
                    done_reg     <= '0;
                    emit_cnt_reg <= '0;
                end
                else
                begin
                    done_reg[best_idx_reg] <= 1'b1;
                    emit_cnt_reg           <= emit_cnt_reg + IW'(1);
                end
            end
            else
            begin
                if (cmd.scan)
                begin
                    scan_idx_reg <= scan_idx_reg + IW'(1);
                end
                if (take)
                begin
                    best_valid_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg <= scan_idx_reg;
        if (take)
        begin
            best_reg     <= rdata;
            best_idx_reg <= rd_idx_reg;
        end
        if (cmd.emit)
        begin
            prev_reg              <= best_reg;
            out_reg.sorted_region <= best_reg[WW-1 -: 32];
            out_reg.group_start   <= first_emit || !same_prev;
            out_reg.group_index   <= group_next;
            out_reg.dropped       <= overflow_reg;
            out_reg.last_out      <= finish;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

### sv/stable_multikey_sort_grouper.sv
// Top level of the stable multikey sort grouper.
// Depends on smsg_pkg, smsg_ctrl, smsg_dp (which holds smsg_ram).
//
// Usage:
//   item channel (item_valid / item_stall / item) loads one entry per transfer
//   into the entry RAM in arrival order; one cycle per entry while loading.
//   An entry that arrives with the RAM full is dropped and flags the run.
//   A transfer with last_region set starts emission; item_stall stays high
//   until the final result of the run has been loaded into the output register.
//   Emission runs n passes over the n stored entries, each pass reading the RAM
//   one entry per cycle to find the smallest entry not yet sent (lowest arrival
//   index wins ties). Each pass ends with a drain state, then an emit state that
//   waits while result_stall holds the output register full; the single RAM
//   read port is why the store is scanned anew for every result.
//   result channel (result_valid / result_stall / result) carries one result
//   per entry; a stalled result holds while the next pass already scans.
//   cfg_we / cfg_data write keys_in_use; write it only while idle.
//   rst_n (asynchronous) empties the store, clears keys_in_use and the flags.
module stable_multikey_sort_grouper #(
    parameter int MAX_REGIONS = smsg_pkg::MaxRegionsDef,
    parameter int MAX_KEYS    = smsg_pkg::MaxKeysDef,
    parameter int KEY_WIDTH   = smsg_pkg::KeyWidthDef
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_stall,
    input  smsg_pkg::item_t               item,
    output logic                          result_valid,
    input  logic                          result_stall,
    output smsg_pkg::result_t             result,
    input  logic                          cfg_we,
    input  logic [smsg_pkg::CfgWidth-1:0] cfg_data
);

    smsg_pkg::cmd_t    cmd;
    smsg_pkg::status_t status;

    smsg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .item_valid(item_valid),
        .item_last (item.last_region),
        .item_stall(item_stall),
        .status    (status),
        .cmd       (cmd)
    );

    smsg_dp #(
        .MAX_REGIONS(MAX_REGIONS),
        .MAX_KEYS   (MAX_KEYS),
        .KEY_WIDTH  (KEY_WIDTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .cmd         (cmd),
        .status      (status),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result      (result)
    );

endmodule

### dv/smsg_checker.sv
// Checker for the stable multikey sort grouper: watches both channels, predicts
// the sorted, grouped results and compares them. Depends on smsg_pkg.
`timescale 1ns / 100ps
module smsg_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    input  logic               item_stall,
    input  smsg_pkg::item_t    item,
    input  logic               result_valid,
    input  logic               result_stall,
    input  smsg_pkg::result_t  result,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_data,
    output int                 fail_count,
    output int                 pending
);

    localparam int Cap = smsg_pkg::MaxRegionsDef;

    smsg_pkg::item_t   held_entries[$];
    logic              overflow;
    logic [2:0]        key_sel;
    smsg_pkg::result_t sorted_expect[$];

    assign pending = sorted_expect.size();

    function automatic int tuple_order(smsg_pkg::item_t a, smsg_pkg::item_t b, int nk);
        logic signed [31:0] ka[4];
        logic signed [31:0] kb[4];
        ka = '{a.key_0, a.key_1, a.key_2, a.key_3};
        kb = '{b.key_0, b.key_1, b.key_2, b.key_3};
        for (int k = 0; k < nk; k++)
        begin
            if (ka[k] < kb[k]) return -1;
            if (ka[k] > kb[k]) return 1;
        end
        if (a.element_type < b.element_type) return -1;
        if (a.element_type > b.element_type) return 1;
        return 0;
    endfunction

    task automatic sort_and_group();
        smsg_pkg::item_t   ord[$];
        smsg_pkg::item_t   cur;
        int                nk;
        int                j;
        int                grp;
        smsg_pkg::result_t r;
        nk = (key_sel > 4) ? 4 : int'(key_sel);
        ord = {};
        foreach (held_entries[i])
        begin
            cur = held_entries[i];
            j = ord.size();
            while (j > 0 && tuple_order(ord[j-1], cur, nk) > 0) j--;
            ord.insert(j, cur);
        end
        grp = 0;
        foreach (ord[i])
        begin
            r.group_start = (i == 0) || (tuple_order(ord[i-1], ord[i], nk) != 0);
            if (r.group_start && i != 0) grp++;
            r.sorted_region = ord[i].region_number;
            r.group_index = grp[5:0];
            r.dropped = overflow;
            r.last_out = (i == ord.size() - 1);
            sorted_expect.insert(sorted_expect.size(), r);
        end
        held_entries = {};
        overflow = 1'b0;
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $time);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        smsg_pkg::result_t w;
        if (!rst_n)
        begin
            held_entries = {};
            sorted_expect = {};
            overflow = 1'b0;
            key_sel = '0;
            fail_count = 0;
        end
        else
        begin
            if (cfg_we) key_sel = cfg_data;
            if (item_valid && !item_stall)
            begin
                if (held_entries.size() < Cap)
                    held_entries.insert(held_entries.size(), item);
                else overflow = 1'b1;
                if (item.last_region) sort_and_group();
            end
            if (result_valid && !result_stall)
            begin
                if (sorted_expect.size() == 0)
                    report_mismatch("unexpected transfer", result.sorted_region, 32'd0);
                else
                begin
                    w = sorted_expect.pop_front();
                    if (result.sorted_region !== w.sorted_region)
                        report_mismatch("sorted_region", result.sorted_region,
                                        w.sorted_region);
                    if (result.group_start !== w.group_start)
                        report_mismatch("group_start", 32'(result.group_start),
                                        32'(w.group_start));
                    if (result.group_index !== w.group_index)
                        report_mismatch("group_index", 32'(result.group_index),
                                        32'(w.group_index));
                    if (result.dropped !== w.dropped)
                        report_mismatch("dropped", 32'(result.dropped), 32'(w.dropped));
                    if (result.last_out !== w.last_out)
                        report_mismatch("last_out", 32'(result.last_out), 32'(w.last_out));
                end
            end
        end
    end
endmodule

### dv/tb_top.sv
// Testbench top for the stable multikey sort grouper: makes stimulus and gives
// the verdict. Depends on smsg_pkg, smsg_checker and the block's RTL.
`timescale 1ns / 100ps
module tb_top;

    localparam int WatchLimit = 40000;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              item_valid = 1'b0;
    logic              item_stall;
    smsg_pkg::item_t   item = '0;
    logic              result_valid;
    logic              result_stall = 1'b0;
    smsg_pkg::result_t result;
    logic              cfg_we = 1'b0;
    logic [2:0]        cfg_data = '0;
    int                fail_count;
    int                pending;
    int                send_idle_pct = 0;
    int                recv_stall_pct = 0;
    int                quiet_cycles = 0;

    always #5 clk = ~clk;

    stable_multikey_sort_grouper uut (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_stall(item_stall), .item(item),
        .result_valid(result_valid), .result_stall(result_stall), .result(result),
        .cfg_we(cfg_we), .cfg_data(cfg_data)
    );

    smsg_checker chk (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_stall(item_stall), .item(item),
        .result_valid(result_valid), .result_stall(result_stall), .result(result),
        .cfg_we(cfg_we), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending)
    );

    always @(negedge clk)
        result_stall <= ($urandom_range(99) < recv_stall_pct);

    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WatchLimit)
        begin
            $display("stable_multikey_sort_grouper verification failed");
            $finish;
        end
    end

    function automatic logic [31:0] pick_key(int spread);
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return $urandom();
            default: return $urandom_range(spread) - spread / 2;
        endcase
    endfunction

    task automatic send_entry(smsg_pkg::item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid <= 1'b1;
        item <= it;
        @(posedge clk);
        while (item_stall) @(posedge clk);
        @(negedge clk);
        if (it.last_region)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
    endtask

    task automatic send_set(int count, int spread);
        smsg_pkg::item_t it;
        for (int i = 0; i < count; i++)
        begin
            it.region_number = $urandom();
            it.key_0 = pick_key(spread);
            it.key_1 = pick_key(spread);
            it.key_2 = pick_key(spread);
            it.key_3 = pick_key(spread);
            it.element_type = ($urandom_range(3) == 0) ? 4'($urandom()) : 4'($urandom_range(1));
            it.last_region = (i == count - 1);
            send_entry(it);
        end
    endtask

    task automatic write_key_sel(logic [2:0] v);
        while (pending != 0) @(negedge clk);
        repeat (20) @(negedge clk);
        cfg_we <= 1'b1;
        cfg_data <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        smsg_pkg::item_t it;
        int              sent;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        it = '0;
        it.last_region = 1'b1;
        send_entry(it);
        it = '1;
        send_entry(it);
        write_key_sel(3'd4);
        send_set(5, 4);
        send_set(2, 2);
        write_key_sel(3'd7);
        send_set(1, 2);
        send_set(66, 4);
        send_set(3, 2);
        sent = 79;
        for (int ph = 0; sent < 420; ph++)
        begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
                default: begin send_idle_pct = 28; recv_stall_pct = 28; end
            endcase
            write_key_sel(3'($urandom_range(7)));
            for (int s = 0; s < 4; s++)
            begin
                int n;
                n = ($urandom_range(9) == 0) ? $urandom_range(60, 66) : $urandom_range(1, 12);
                send_set(n, $urandom_range(1) ? 4 : 1000);
                sent += n;
            end
        end
        while (pending != 0) @(negedge clk);
        repeat (50) @(negedge clk);
        if (fail_count == 0)
            $display("stable_multikey_sort_grouper verification clean");
        else
            $display("stable_multikey_sort_grouper verification failed");
        $finish;
    end
endmodule

### sim.f
sv/smsg_pkg.sv
sv/smsg_ram.sv
sv/smsg_ctrl.sv
sv/smsg_dp.sv
sv/stable_multikey_sort_grouper.sv
dv/smsg_checker.sv
dv/tb_top.sv
